// File: rtl/command_line_history_engine_defines.svh
// Assertion macros for the RTL file that carries checks.
`ifndef COMMAND_LINE_HISTORY_ENGINE_DEFINES_SVH
`define COMMAND_LINE_HISTORY_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define CLHE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define CLHE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CLHE_ASSERT_NOW(lbl, ante, cons, msg)
`define CLHE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/clhe_pkg.sv
`default_nettype none
package clhe_pkg;

    // Default sizes.
    localparam int HISTORY_BYTES_DEF = 256;
    localparam int ENTRIES_DEF       = 16;
    localparam int LINE_BYTES_DEF    = 64;

    // Fixed field widths.
    localparam int KEY_W = 8;
    localparam int LEN_W = 7;

    // Key codes.
    localparam logic [KEY_W-1:0] KEY_UP        = 8'd11;
    localparam logic [KEY_W-1:0] KEY_DOWN      = 8'd12;
    localparam logic [KEY_W-1:0] KEY_ENTER     = 8'h0D;
    localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'h08;
    localparam logic [KEY_W-1:0] BYTE_CR       = 8'h0D;

    // Datapath operations issued by the controller.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
    localparam logic [OP_W-1:0] OP_KEY   = 3'd1;
    localparam logic [OP_W-1:0] OP_STASH = 3'd2;
    localparam logic [OP_W-1:0] OP_FETCH = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD  = 3'd4;
    localparam logic [OP_W-1:0] OP_SHOW  = 3'd5;
    localparam logic [OP_W-1:0] OP_STORE = 3'd6;
    localparam logic [OP_W-1:0] OP_MARK  = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic key_up;
        logic key_down;
        logic key_enter;
        logic browse_live;
        logic browse_first;
        logic live_empty;
        logic stash_empty;
        logic age_ok;
        logic len_zero;
        logic copy_done;
    } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/clhe_ctrl.sv
`default_nettype none
module clhe_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  clhe_pkg::dp_status_t status,
    output clhe_pkg::dp_cmd_t   cmd,
    output logic                busy
);
    import clhe_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_STASH = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_SHOW  = 3'd4;
    localparam logic [2:0] S_STORE = 3'd5;
    localparam logic [2:0] S_MARK  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign busy = (state_reg != S_IDLE);

    // Next state and the operation for the datapath in this cycle.
    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op = OP_KEY;
                    if (status.key_up)
                    begin
                        state_next = status.browse_live ? S_STASH : S_FETCH;
                    end
                    else if (status.key_down)
                    begin
                        if (status.browse_live)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (status.browse_first)
                        begin
                            state_next = status.stash_empty ? S_IDLE : S_SHOW;
                        end
                        else
                        begin
                            state_next = S_FETCH;
                        end
                    end
                    else if (status.key_enter)
                    begin
                        state_next = status.live_empty ? S_IDLE : S_STORE;
                    end
                end
            end
            S_STASH:
            begin
                cmd.op = OP_STASH;
                if (status.copy_done)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.op     = OP_FETCH;
                state_next = status.age_ok ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                cmd.op     = OP_LOAD;
                state_next = status.len_zero ? S_IDLE : S_SHOW;
            end
            S_SHOW:
            begin
                cmd.op = OP_SHOW;
                if (status.copy_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_STORE:
            begin
                cmd.op = OP_STORE;
                if (status.copy_done)
                begin
                    state_next = S_MARK;
                end
            end
            S_MARK:
            begin
                cmd.op     = OP_MARK;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/clhe_datapath.sv
`default_nettype none
module clhe_datapath #(
    parameter int HISTORY_BYTES = clhe_pkg::HISTORY_BYTES_DEF,
    parameter int ENTRIES       = clhe_pkg::ENTRIES_DEF,
    parameter int LINE_BYTES    = clhe_pkg::LINE_BYTES_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  [clhe_pkg::KEY_W-1:0]       key_code,
    input  clhe_pkg::dp_cmd_t                cmd,
    output clhe_pkg::dp_status_t             status,
    output logic                             strobe,
    output logic [clhe_pkg::LEN_W-1:0]       erase_count,
    output logic [7:0]                       echo_byte,
    output logic                             byte_valid,
    output logic                             nav_key,
    output logic                             last
);
    import clhe_pkg::*;

    localparam int HW = $clog2(HISTORY_BYTES);
    localparam int EW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int LW = $clog2(LINE_BYTES);

    // Memories.
    logic [7:0]       hist_mem      [HISTORY_BYTES];
    logic [HW-1:0]    ent_start_mem [ENTRIES];
    logic [LEN_W-1:0] ent_len_mem   [ENTRIES];
    logic [7:0]       stash_mem     [LINE_BYTES];
    logic [7:0]       live_mem      [LINE_BYTES];

    // Registered read data.
    logic [7:0]       live_q;
    logic [7:0]       stash_q;
    logic [7:0]       hist_q;
    logic [HW-1:0]    estart_q;
    logic [LEN_W-1:0] elen_q;

    // Control and working registers.
    logic [LEN_W-1:0] live_len_reg,  live_len_next;
    logic [LEN_W-1:0] stash_len_reg, stash_len_next;
    logic [CW-1:0]    bpos_reg,      bpos_next;
    logic [CW-1:0]    count_reg,     count_next;
    logic [EW-1:0]    newest_reg,    newest_next;
    logic [HW-1:0]    wp_reg,        wp_next;
    logic [HW-1:0]    hptr_reg,      hptr_next;
    logic [HW-1:0]    entry_wp_reg,  entry_wp_next;
    logic [KEY_W-1:0] key_reg,       key_next;
    logic [LEN_W-1:0] erase_reg,     erase_next;
    logic [LEN_W-1:0] len_reg,       len_next;
    logic [LEN_W-1:0] idx_reg,       idx_next;
    logic [LEN_W-1:0] pidx_reg,      pidx_next;
    logic             pend_reg,      pend_next;
    logic             src_stash_reg, src_stash_next;

    // Result registers.
    logic             strobe_reg,  strobe_next;
    logic [LEN_W-1:0] o_erase_reg, o_erase_next;
    logic [7:0]       o_byte_reg,  o_byte_next;
    logic             o_valid_reg, o_valid_next;
    logic             o_nav_reg,   o_nav_next;
    logic             o_last_reg,  o_last_next;

    // Write ports.
    logic             live_we, stash_we, hist_we, ent_we;
    logic [LW-1:0]    live_waddr;
    logic [7:0]       live_wdata, hist_wdata;

    // Helpers.
    logic [CW-1:0]    age;
    logic             age_ok;
    logic [EW:0]      slot_sum;
    logic [EW-1:0]    slot;
    logic [EW-1:0]    newest_inc;
    logic [HW-1:0]    wp_inc;
    logic [HW-1:0]    hptr_inc;
    logic             is_copy;
    logic             copy_done;
    logic [7:0]       src_data;

    // Age of the entry to recall and its slot in the entry ring.
    assign age      = (key_reg == KEY_UP) ? bpos_reg : (bpos_reg - CW'(2));
    assign age_ok   = (age < count_reg);
    assign slot_sum = {1'b0, newest_reg} + (EW+1)'(ENTRIES) - (EW+1)'(age);
    assign slot     = (slot_sum >= (EW+1)'(ENTRIES)) ?
                      EW'(slot_sum - (EW+1)'(ENTRIES)) : slot_sum[EW-1:0];

    // Ring increments.
    assign newest_inc = (newest_reg == EW'(ENTRIES - 1)) ? '0 : newest_reg + EW'(1);
    assign wp_inc     = (wp_reg == HW'(HISTORY_BYTES - 1)) ? '0 : wp_reg + HW'(1);
    assign hptr_inc   = (hptr_reg == HW'(HISTORY_BYTES - 1)) ? '0 : hptr_reg + HW'(1);

    assign is_copy   = (cmd.op == OP_STASH) || (cmd.op == OP_SHOW) || (cmd.op == OP_STORE);
    assign copy_done = (idx_reg == len_reg) && !pend_reg;
    assign src_data  = src_stash_reg ? stash_q : hist_q;

    // Status to the controller.
    always_comb
    begin
        status.key_up       = (key_code == KEY_UP);
        status.key_down     = (key_code == KEY_DOWN);
        status.key_enter    = (key_code == KEY_ENTER);
        status.browse_live  = (bpos_reg == '0);
        status.browse_first = (bpos_reg == CW'(1));
        status.live_empty   = (live_len_reg == '0);
        status.stash_empty  = (stash_len_reg == '0);
        status.age_ok       = age_ok;
        status.len_zero     = (elen_q == '0);
        status.copy_done    = copy_done;
    end

    // Operation decode.
    always_comb
    begin
        live_len_next  = live_len_reg;
        stash_len_next = stash_len_reg;
        bpos_next      = bpos_reg;
        count_next     = count_reg;
        newest_next    = newest_reg;
        wp_next        = wp_reg;
        hptr_next      = hptr_reg;
        entry_wp_next  = entry_wp_reg;
        key_next       = key_reg;
        erase_next     = erase_reg;
        len_next       = len_reg;
        idx_next       = idx_reg;
        pidx_next      = pidx_reg;
        pend_next      = pend_reg;
        src_stash_next = src_stash_reg;
        strobe_next    = 1'b0;
        o_erase_next   = '0;
        o_byte_next    = '0;
        o_valid_next   = 1'b0;
        o_nav_next     = 1'b0;
        o_last_next    = 1'b0;
        live_we        = 1'b0;
        stash_we       = 1'b0;
        hist_we        = 1'b0;
        ent_we         = 1'b0;
        live_waddr     = live_len_reg[LW-1:0];
        live_wdata     = key_code;
        hist_wdata     = live_q;

        // Streaming copy: issue one read per cycle and write its data in the next cycle.
        if (is_copy)
        begin
            if (idx_reg != len_reg)
            begin
                idx_next  = idx_reg + LEN_W'(1);
                pidx_next = idx_reg;
                pend_next = 1'b1;
                if ((cmd.op == OP_SHOW) && !src_stash_reg)
                begin
                    hptr_next = hptr_inc;
                end
            end
            else
            begin
                pend_next = 1'b0;
            end
        end

        case (cmd.op)
            OP_KEY:
            begin
                key_next   = key_code;
                erase_next = live_len_reg;
                idx_next   = '0;
                pend_next  = 1'b0;
                if (key_code == KEY_UP)
                begin
                    src_stash_next = 1'b0;
                    if (bpos_reg == '0)
                    begin
                        stash_len_next = live_len_reg;
                        len_next       = live_len_reg;
                    end
                end
                else if (key_code == KEY_DOWN)
                begin
                    if (bpos_reg == '0)
                    begin
                        strobe_next = 1'b1;
                        o_nav_next  = 1'b1;
                        o_last_next = 1'b1;
                    end
                    else if (bpos_reg == CW'(1))
                    begin
                        bpos_next      = '0;
                        src_stash_next = 1'b1;
                        len_next       = stash_len_reg;
                        live_len_next  = stash_len_reg;
                        if (stash_len_reg == '0)
                        begin
                            strobe_next  = 1'b1;
                            o_erase_next = live_len_reg;
                            o_nav_next   = 1'b1;
                            o_last_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        src_stash_next = 1'b0;
                    end
                end
                else if (key_code == KEY_ENTER)
                begin
                    bpos_next = '0;
                    if (live_len_reg != '0)
                    begin
                        len_next      = live_len_reg;
                        entry_wp_next = wp_reg;
                    end
                    else
                    begin
                        strobe_next  = 1'b1;
                        o_byte_next  = BYTE_CR;
                        o_valid_next = 1'b1;
                        o_last_next  = 1'b1;
                    end
                end
                else if (key_code == KEY_BACKSPACE)
                begin
                    strobe_next = 1'b1;
                    o_last_next = 1'b1;
                    if (live_len_reg != '0)
                    begin
                        live_len_next = live_len_reg - LEN_W'(1);
                        o_erase_next  = LEN_W'(1);
                    end
                end
                else
                begin
                    strobe_next = 1'b1;
                    o_last_next = 1'b1;
                    if (live_len_reg < LEN_W'(LINE_BYTES))
                    begin
                        live_we       = 1'b1;
                        live_len_next = live_len_reg + LEN_W'(1);
                        o_byte_next   = key_code;
                        o_valid_next  = 1'b1;
                    end
                end
            end
            OP_STASH:
            begin
                stash_we = pend_reg;
            end
            OP_FETCH:
            begin
                if (!age_ok)
                begin
                    strobe_next = 1'b1;
                    o_nav_next  = 1'b1;
                    o_last_next = 1'b1;
                end
            end
            OP_LOAD:
            begin
                hptr_next     = estart_q;
                len_next      = elen_q;
                live_len_next = elen_q;
                idx_next      = '0;
                pend_next     = 1'b0;
                bpos_next     = (key_reg == KEY_UP) ? bpos_reg + CW'(1) : bpos_reg - CW'(1);
                if (elen_q == '0)
                begin
                    strobe_next  = 1'b1;
                    o_erase_next = erase_reg;
                    o_nav_next   = 1'b1;
                    o_last_next  = 1'b1;
                end
            end
            OP_SHOW:
            begin
                if (pend_reg)
                begin
                    live_we      = 1'b1;
                    live_waddr   = pidx_reg[LW-1:0];
                    live_wdata   = src_data;
                    strobe_next  = 1'b1;
                    o_erase_next = (pidx_reg == '0) ? erase_reg : '0;
                    o_byte_next  = src_data;
                    o_valid_next = 1'b1;
                    o_nav_next   = 1'b1;
                    o_last_next  = (pidx_reg == len_reg - LEN_W'(1));
                end
            end
            OP_STORE:
            begin
                if (pend_reg)
                begin
                    hist_we = 1'b1;
                    wp_next = wp_inc;
                end
            end
            OP_MARK:
            begin
                hist_we       = 1'b1;
                hist_wdata    = BYTE_CR;
                wp_next       = wp_inc;
                ent_we        = 1'b1;
                newest_next   = newest_inc;
                live_len_next = '0;
                if (count_reg != CW'(ENTRIES))
                begin
                    count_next = count_reg + CW'(1);
                end
                strobe_next  = 1'b1;
                o_byte_next  = BYTE_CR;
                o_valid_next = 1'b1;
                o_last_next  = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Memory writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (live_we)
        begin
            live_mem[live_waddr] <= live_wdata;
        end
        if (stash_we)
        begin
            stash_mem[pidx_reg[LW-1:0]] <= live_q;
        end
        if (hist_we)
        begin
            hist_mem[wp_reg] <= hist_wdata;
        end
        if (ent_we)
        begin
            ent_start_mem[newest_inc] <= entry_wp_reg;
            ent_len_mem[newest_inc]   <= len_reg;
        end
        live_q   <= live_mem[idx_reg[LW-1:0]];
        stash_q  <= stash_mem[idx_reg[LW-1:0]];
        hist_q   <= hist_mem[hptr_reg];
        estart_q <= ent_start_mem[slot];
        elen_q   <= ent_len_mem[slot];
    end

    // Register update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_len_reg  <= '0;
            stash_len_reg <= '0;
            bpos_reg      <= '0;
            count_reg     <= '0;
            newest_reg    <= '0;
            wp_reg        <= '0;
            hptr_reg      <= '0;
            entry_wp_reg  <= '0;
            key_reg       <= '0;
            erase_reg     <= '0;
            len_reg       <= '0;
            idx_reg       <= '0;
            pidx_reg      <= '0;
            pend_reg      <= 1'b0;
            src_stash_reg <= 1'b0;
            strobe_reg    <= 1'b0;
            o_erase_reg   <= '0;
            o_byte_reg    <= '0;
            o_valid_reg   <= 1'b0;
            o_nav_reg     <= 1'b0;
            o_last_reg    <= 1'b0;
        end
        else
        begin
            live_len_reg  <= live_len_next;
            stash_len_reg <= stash_len_next;
            bpos_reg      <= bpos_next;
            count_reg     <= count_next;
            newest_reg    <= newest_next;
            wp_reg        <= wp_next;
            hptr_reg      <= hptr_next;
            entry_wp_reg  <= entry_wp_next;
            key_reg       <= key_next;
            erase_reg     <= erase_next;
            len_reg       <= len_next;
            idx_reg       <= idx_next;
            pidx_reg      <= pidx_next;
            pend_reg      <= pend_next;
            src_stash_reg <= src_stash_next;
            strobe_reg    <= strobe_next;
            o_erase_reg   <= o_erase_next;
            o_byte_reg    <= o_byte_next;
            o_valid_reg   <= o_valid_next;
            o_nav_reg     <= o_nav_next;
            o_last_reg    <= o_last_next;
        end
    end

    assign strobe      = strobe_reg;
    assign erase_count = o_erase_reg;
    assign echo_byte   = o_byte_reg;
    assign byte_valid  = o_valid_reg;
    assign nav_key     = o_nav_reg;
    assign last        = o_last_reg;

endmodule
`default_nettype wire

// File: rtl/command_line_history_engine.sv
// Channel   Direction  Ports                                             Transfer
// key       in         start, busy, key_code                             start && !busy
// result    out        strobe, erase_count, echo_byte, byte_valid,       strobe
//                      nav_key, last
//
// Character, backspace, Enter on an empty line, down on the live line and down to an empty
// stashed line: one result in the next cycle; busy stays low.
// Enter on a non-empty line: busy while the line is copied into the history and its entry
// is recorded. Recall of an entry: busy while it is fetched, loaded and shown; up from the
// live line first stashes that line. Down to a non-empty stashed line: busy while it is shown.
// Results stream one per cycle and cannot be stalled; reset clears control state only.
`default_nettype none
`include "command_line_history_engine_defines.svh"
module command_line_history_engine #(
    parameter int HISTORY_BYTES = clhe_pkg::HISTORY_BYTES_DEF,
    parameter int ENTRIES       = clhe_pkg::ENTRIES_DEF,
    parameter int LINE_BYTES    = clhe_pkg::LINE_BYTES_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire  [clhe_pkg::KEY_W-1:0]  key_code,
    output logic                        busy,
    output logic                        strobe,
    output logic [clhe_pkg::LEN_W-1:0]  erase_count,
    output logic [7:0]                  echo_byte,
    output logic                        byte_valid,
    output logic                        nav_key,
    output logic                        last
);
    import clhe_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       plain_key;

    // Sequencer.
    clhe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Line, stash and history storage.
    clhe_datapath #(
        .HISTORY_BYTES (HISTORY_BYTES),
        .ENTRIES       (ENTRIES),
        .LINE_BYTES    (LINE_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_code    (key_code),
        .cmd         (cmd),
        .status      (status),
        .strobe      (strobe),
        .erase_count (erase_count),
        .echo_byte   (echo_byte),
        .byte_valid  (byte_valid),
        .nav_key     (nav_key),
        .last        (last)
    );

    // An accepted key that is neither navigation, Enter nor backspace.
    assign plain_key = start && !busy && (key_code != KEY_UP) && (key_code != KEY_DOWN) &&
                       (key_code != KEY_ENTER) && (key_code != KEY_BACKSPACE);

    // A typed character is answered in the very next cycle with a final result.
    `CLHE_ASSERT_NEXT(a_char_answer, plain_key, strobe && last, "character key not answered")
    // A recalled line streams without gaps.
    `CLHE_ASSERT_NEXT(a_stream_gapless, strobe && !last, strobe, "gap in result stream")
    // A result with no byte carries a zero byte.
    `CLHE_ASSERT_NOW(a_empty_byte, strobe && !byte_valid, echo_byte == 8'd0, "echo byte set without valid")
    // Only the first result of a recall erases.
    `CLHE_ASSERT_NEXT(a_erase_first, strobe && !last, erase_count == '0, "erase in later result")

endmodule
`default_nettype wire

// File: bench/clhe_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module clhe_checker (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    input  wire        busy,
    input  wire [7:0]  key_code,
    input  wire        strobe,
    input  wire [6:0]  erase_count,
    input  wire [7:0]  echo_byte,
    input  wire        byte_valid,
    input  wire        nav_key,
    input  wire        last,
    output int         fail_count,
    output int         pending_results,
    output int         result_total
);
    import clhe_pkg::*;

    localparam int RING  = HISTORY_BYTES_DEF;
    localparam int SLOTS = ENTRIES_DEF;
    localparam int LINE  = LINE_BYTES_DEF;

    typedef struct packed {
        logic [6:0] erase;
        logic [7:0] echo;
        logic       valid;
        logic       nav;
        logic       fin;
    } echo_t;

    echo_t      echo_queue[$];

    // Shadow copy of the line editor and its history.
    logic [7:0] ring_mem[RING];
    logic [7:0] slot_start[SLOTS];
    logic [6:0] slot_len[SLOTS];
    int         used_slots;
    int         newest_slot;
    int         wr_ptr;
    int         browse_idx;
    logic [7:0] stash_buf[LINE];
    int         stash_len;
    logic [7:0] typed_line[LINE];
    int         typed_len;

    assign pending_results = echo_queue.size();

    // Note one result; the last flag is fixed up once the key is complete.
    task automatic push_echo(input int erase, input logic [7:0] b, input logic v,
                             input logic nav);
        echo_t e;
        e.erase = erase[6:0];
        e.echo  = v ? b : 8'h00;
        e.valid = v;
        e.nav   = nav;
        e.fin   = 1'b0;
        echo_queue.push_back(e);
    endtask

    // Replace the live line with a recalled one and predict its echo.
    task automatic show_recalled(input logic [7:0] src[LINE], input int len);
        int erase;
        erase = typed_len;
        if (len == 0)
            push_echo(erase, 8'h00, 1'b0, 1'b1);
        for (int i = 0; i < len; i++)
        begin
            push_echo(i == 0 ? erase : 0, src[i], 1'b1, 1'b1);
            typed_line[i] = src[i];
        end
        typed_len = len;
    endtask

    task automatic recall_age(input int age);
        logic [7:0] tmp[LINE];
        int slot;
        int len;
        slot = (newest_slot + SLOTS - (age % SLOTS)) % SLOTS;
        len  = slot_len[slot];
        for (int i = 0; i < len; i++)
            tmp[i] = ring_mem[(slot_start[slot] + i) % RING];
        show_recalled(tmp, len);
    endtask

    task automatic predict_key(input logic [7:0] k);
        int before_size;
        before_size = echo_queue.size();
        if (k == KEY_UP)
        begin
            if (browse_idx < 0)
            begin
                stash_len = typed_len;
                for (int i = 0; i < typed_len; i++)
                    stash_buf[i] = typed_line[i];
            end
            if (browse_idx + 1 < used_slots)
            begin
                browse_idx++;
                recall_age(browse_idx);
            end
            else
                push_echo(0, 8'h00, 1'b0, 1'b1);
        end
        else if (k == KEY_DOWN)
        begin
            if (browse_idx < 0)
                push_echo(0, 8'h00, 1'b0, 1'b1);
            else if (browse_idx == 0)
            begin
                browse_idx = -1;
                show_recalled(stash_buf, stash_len);
            end
            else
            begin
                browse_idx--;
                recall_age(browse_idx);
            end
        end
        else if (k == KEY_ENTER)
        begin
            if (typed_len > 0)
            begin
                for (int i = 0; i < typed_len; i++)
                    ring_mem[(wr_ptr + i) % RING] = typed_line[i];
                ring_mem[(wr_ptr + typed_len) % RING] = BYTE_CR;
                newest_slot = (newest_slot + 1) % SLOTS;
                slot_start[newest_slot] = wr_ptr[7:0];
                slot_len[newest_slot]   = typed_len[6:0];
                wr_ptr = (wr_ptr + typed_len + 1) % RING;
                if (used_slots < SLOTS)
                    used_slots++;
            end
            typed_len  = 0;
            browse_idx = -1;
            push_echo(0, BYTE_CR, 1'b1, 1'b0);
        end
        else if (k == KEY_BACKSPACE)
        begin
            if (typed_len > 0)
            begin
                typed_len--;
                push_echo(1, 8'h00, 1'b0, 1'b0);
            end
            else
                push_echo(0, 8'h00, 1'b0, 1'b0);
        end
        else if (typed_len < LINE)
        begin
            typed_line[typed_len] = k;
            typed_len++;
            push_echo(0, k, 1'b1, 1'b0);
        end
        else
            push_echo(0, 8'h00, 1'b0, 1'b0);
        if (echo_queue.size() > before_size)
            echo_queue[echo_queue.size() - 1].fin = 1'b1;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Predict on each key transfer and compare each result transfer.
    always @(posedge clk or negedge rst_n)
    begin
        echo_t e;
        if (!rst_n)
        begin
            echo_queue.delete();
            fail_count   = 0;
            result_total = 0;
            used_slots   = 0;
            newest_slot  = 0;
            wr_ptr       = 0;
            browse_idx   = -1;
            stash_len    = 0;
            typed_len    = 0;
        end
        else
        begin
            if (strobe)
            begin
                result_total++;
                if (echo_queue.size() == 0)
                    report_mismatch("unexpected result, echo", echo_byte, -1);
                else
                begin
                    e = echo_queue.pop_front();
                    if (erase_count !== e.erase)
                        report_mismatch("erase_count", erase_count, e.erase);
                    if (echo_byte !== e.echo)
                        report_mismatch("echo_byte", echo_byte, e.echo);
                    if (byte_valid !== e.valid)
                        report_mismatch("byte_valid", byte_valid, e.valid);
                    if (nav_key !== e.nav)
                        report_mismatch("nav_key", nav_key, e.nav);
                    if (last !== e.fin)
                        report_mismatch("last", last, e.fin);
                end
            end
            if (start && !busy)
                predict_key(key_code);
        end
    end
endmodule
`default_nettype wire

// File: bench/tb_command_line_history_engine.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_command_line_history_engine;
    import clhe_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic [7:0] key_code;
    wire        busy;
    wire        strobe;
    wire [6:0]  erase_count;
    wire [7:0]  echo_byte;
    wire        byte_valid;
    wire        nav_key;
    wire        last;
    int         fail_count;
    int         pending_results;
    int         result_total;
    int         idle_cycles;
    int         keys_sent;
    logic       calm_stretch;

    command_line_history_engine uut (
        .clk(clk), .rst_n(rst_n), .start(start), .key_code(key_code), .busy(busy),
        .strobe(strobe), .erase_count(erase_count), .echo_byte(echo_byte),
        .byte_valid(byte_valid), .nav_key(nav_key), .last(last)
    );

    clhe_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .key_code(key_code),
        .strobe(strobe), .erase_count(erase_count), .echo_byte(echo_byte),
        .byte_valid(byte_valid), .nav_key(nav_key), .last(last),
        .fail_count(fail_count), .pending_results(pending_results),
        .result_total(result_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: counts cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((start && !busy) || strobe || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Present one key and hold it until the transfer, with random gaps before it unless calm_stretch is set.
    // Start is left high after the transfer; the next call either reuses it or drops it.
    task automatic send_key(input logic [7:0] k);
        if (!calm_stretch)
            while ($urandom_range(99) < 30)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        start    <= 1'b1;
        key_code <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        keys_sent++;
    endtask

    // A printable character, sometimes any byte at all.
    function automatic logic [7:0] any_char();
        logic [7:0] c;
        if ($urandom_range(9) == 0)
            c = 8'($urandom_range(255));
        else
            c = 8'($urandom_range(8'h7E, 8'h20));
        return c;
    endfunction

    task automatic type_line(input int len);
        for (int i = 0; i < len; i++)
            send_key(any_char());
    endtask

    initial
    begin
        int len;
        int pick;
        idle_cycles  = 0;
        keys_sent    = 0;
        calm_stretch = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        key_code     = 8'h00;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: navigation and edits, first on an empty history and line, then with a short history.
        send_key(KEY_DOWN);
        send_key(KEY_UP);
        send_key(KEY_BACKSPACE);
        send_key(KEY_ENTER);
        send_key(8'h00);
        send_key(8'hFF);
        send_key(KEY_BACKSPACE);
        send_key(KEY_ENTER);
        send_key(8'h41);
        send_key(KEY_UP);
        send_key(KEY_UP);
        send_key(8'h42);
        send_key(KEY_DOWN);
        send_key(KEY_DOWN);
        send_key(KEY_ENTER);
        send_key(KEY_UP);
        send_key(KEY_DOWN);
        send_key(KEY_ENTER);
        // Full line, a dropped character, then store it.
        type_line(64);
        send_key(8'h5A);
        send_key(KEY_ENTER);
        send_key(KEY_UP);

        // Random sessions: mostly typed commands and browsing, with some noise.
        while (keys_sent < 300)
        begin
            calm_stretch = (keys_sent > 160 && keys_sent < 220);
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                len = ($urandom_range(19) == 0) ? $urandom_range(64, 50)
                                                : $urandom_range(8, 0);
                type_line(len);
                if ($urandom_range(3) == 0)
                    send_key(KEY_BACKSPACE);
                send_key(KEY_ENTER);
            end
            else if (pick < 75)
            begin
                type_line($urandom_range(3, 0));
                repeat ($urandom_range(18, 1))
                    send_key($urandom_range(2) == 0 ? KEY_DOWN : KEY_UP);
                if ($urandom_range(1))
                    type_line($urandom_range(2, 0));
                if ($urandom_range(1))
                    send_key(KEY_ENTER);
            end
            else
            begin
                pick = $urandom_range(4);
                if (pick == 0)
                    send_key(KEY_BACKSPACE);
                else if (pick == 1)
                    send_key(8'($urandom_range(255)));
                else
                    send_key(any_char());
            end
        end
        start <= 1'b0;

        // Drain the outstanding results, then allow for the recall latency.
        while (pending_results != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Sent %0d keys and checked %0d results, covering typing, backspace,",
                 keys_sent, result_total);
        $display("entry, history recall in both directions and ring wrap-around.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
